// ===== sv/fixed_point_sixteenth_root_unit_assert.svh =====
// assertion macros shared by the sixteenth root unit
`ifndef FIXED_POINT_SIXTEENTH_ROOT_UNIT_ASSERT_SVH
`define FIXED_POINT_SIXTEENTH_ROOT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// checked outside reset only
`define FSR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define FSR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define FSR_ASSERT(lbl, clk, rst_n, prop, msg)
`define FSR_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/fsr_pkg.sv =====
package fsr_pkg;

  localparam int FSR_ITERATIONS = 128;
  localparam int FSR_ROOT_ORDER = 16;

  localparam int FSR_RAD_W     = 64;
  localparam int FSR_RAD_FRAC  = 40;
  localparam int FSR_PROD_FRAC = 64;
  localparam int FSR_W         = 128;
  localparam int FSR_HALF_W    = FSR_W / 2;
  localparam int FSR_ROOT_ONE  = 126;
  localparam int FSR_LIMIT_UP  = FSR_PROD_FRAC - FSR_RAD_FRAC;
  localparam int FSR_LIMIT_TOP = FSR_W - FSR_RAD_W - FSR_LIMIT_UP;

  localparam int FSR_K_W = (FSR_ITERATIONS > 1) ? $clog2(FSR_ITERATIONS) : 1;
  localparam int FSR_J_W = $clog2(FSR_ROOT_ORDER);

  // 1.0 in the product format (Q64.64) and in the root format (Q2.126)
  localparam logic [FSR_W-1:0] FSR_F_ONE =
    {{(FSR_W - FSR_PROD_FRAC - 1){1'b0}}, 1'b1, {FSR_PROD_FRAC{1'b0}}};
  localparam logic [FSR_W-1:0] FSR_R_ONE =
    {{(FSR_W - FSR_ROOT_ONE - 1){1'b0}}, 1'b1, {FSR_ROOT_ONE{1'b0}}};

  typedef struct packed {
    logic               load;
    logic               step;
    logic               update;
    logic [FSR_K_W-1:0] shamt;
  } fsr_cmd_t;

endpackage

// ===== sv/fsr_ctrl.sv =====
`include "fixed_point_sixteenth_root_unit_assert.svh"

module fsr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  output fsr_pkg::fsr_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_STEP = 4'b0010,
    S_UPD  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e                      state_q, state_d;
  logic [fsr_pkg::FSR_K_W-1:0] k_q, k_d;
  logic [fsr_pkg::FSR_J_W-1:0] j_q, j_d;
  logic                        accept;

  assign busy_o = !(state_q == S_IDLE || state_q == S_DONE);
  assign done_o = (state_q == S_DONE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    j_d          = j_q;
    cmd_o.load   = 1'b0;
    cmd_o.step   = 1'b0;
    cmd_o.update = 1'b0;
    cmd_o.shamt  = k_q;
    unique case (state_q) inside
      S_IDLE, S_DONE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          k_d        = '0;
          j_d        = '0;
          state_d    = S_STEP;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        if (j_q == fsr_pkg::FSR_J_W'(fsr_pkg::FSR_ROOT_ORDER - 1)) begin
          j_d     = '0;
          state_d = S_UPD;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        if (k_q == fsr_pkg::FSR_K_W'(fsr_pkg::FSR_ITERATIONS - 1)) begin
          state_d = S_DONE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_STEP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      j_q     <= j_d;
    end
  end

  `FSR_ASSERT(a_done_one_cycle, clk_i, rst_ni, done_o |=> !done_o, "done strobe too long")
  `FSR_ASSERT(a_update_after_step, clk_i, rst_ni, cmd_o.update |-> $past(cmd_o.step), "lone update")
  `FSR_ASSERT(a_accept_starts, clk_i, rst_ni, accept |=> (state_q == S_STEP && k_q == '0), "bad start")
  `FSR_ASSERT_ALWAYS(a_no_step_on_done, clk_i, !(done_o && (cmd_o.step || cmd_o.update)), "busy on done")

endmodule

// ===== sv/fsr_datapath.sv =====
`include "fixed_point_sixteenth_root_unit_assert.svh"

module fsr_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fsr_pkg::fsr_cmd_t             cmd_i,
  input  logic [fsr_pkg::FSR_RAD_W-1:0] radicand_i,
  output logic [fsr_pkg::FSR_W-1:0]     root_o
);

  logic [fsr_pkg::FSR_RAD_W-1:0] rad_q;
  logic [fsr_pkg::FSR_W-1:0]     u_q, f_q, root_q;
  logic [fsr_pkg::FSR_W-1:0]     limit, opnd, sum;
  logic                          fits;

  // radicand seen as Q64.64
  assign limit = {{fsr_pkg::FSR_LIMIT_TOP{1'b0}}, rad_q, {fsr_pkg::FSR_LIMIT_UP{1'b0}}};

  // one shared add-shift: candidate during steps, root on update
  assign opnd = cmd_i.update ? root_q : u_q;
  assign sum  = opnd + (opnd >> cmd_i.shamt);
  assign fits = (u_q <= limit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      u_q    <= fsr_pkg::FSR_F_ONE;
      f_q    <= fsr_pkg::FSR_F_ONE;
      root_q <= fsr_pkg::FSR_R_ONE;
    end else if (cmd_i.load) begin
      rad_q  <= radicand_i;
      u_q    <= fsr_pkg::FSR_F_ONE;
      f_q    <= fsr_pkg::FSR_F_ONE;
      root_q <= fsr_pkg::FSR_R_ONE;
    end else if (cmd_i.step) begin
      u_q <= sum;
    end else if (cmd_i.update) begin
      if (fits) begin
        f_q    <= u_q;
        root_q <= sum;
      end else begin
        // rejected candidate, restart from the kept product
        u_q <= f_q;
      end
    end
  end

  assign root_o = root_q;

  `FSR_ASSERT(a_f_bounded, clk_i, rst_ni, (f_q <= limit) || (f_q == fsr_pkg::FSR_F_ONE), "product exceeds radicand")

endmodule

// ===== sv/fixed_point_sixteenth_root_unit.sv =====
// channel   ports                               handshake
// --------  ----------------------------------  --------------------------------
// in        radicand_i                          beat taken when start && !busy
// out       root_high_o, root_low_o             beat on done_o, one cycle only
//
// an item runs 128 normalization steps, each made of add-shifts, as many as the
// root order, and then a compare/update, all on one shared 128-bit adder
// done_o flags the result for one cycle; a new start is taken in that
// same cycle, so a new item is taken only once the last one is done
// reset is asynchronous, active low, and returns the controller to idle
// the receiver cannot stall: done_o strobes; the root holds until the next start
module fixed_point_sixteenth_root_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [fsr_pkg::FSR_RAD_W-1:0]   radicand_i,
  output logic                            done_o,
  output logic [fsr_pkg::FSR_HALF_W-1:0]  root_high_o,
  output logic [fsr_pkg::FSR_HALF_W-1:0]  root_low_o
);

  fsr_pkg::fsr_cmd_t         cmd;
  logic [fsr_pkg::FSR_W-1:0] root;

  fsr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  fsr_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .radicand_i (radicand_i),
    .root_o     (root)
  );

  assign root_high_o = root[fsr_pkg::FSR_W-1:fsr_pkg::FSR_HALF_W];
  assign root_low_o  = root[fsr_pkg::FSR_HALF_W-1:0];

endmodule

// ===== tb/sv/fixed_point_sixteenth_root_unit_test.sv =====
`timescale 1ns / 1ps

module fixed_point_sixteenth_root_unit_test;

  localparam int RANDOM_ITEMS = 247;
  localparam int SEGMENT_ITEMS = 30;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [fsr_pkg::FSR_RAD_W-1:0] CORNER_RADICANDS [19] = '{
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0001,
    64'hFFFF_FFFF_FFFF_FFFF,
    64'h0000_0100_0000_0000,
    64'h0000_00FF_FFFF_FFFF,
    64'h0000_0100_0000_0001,
    64'h0001_0000_0000_0000,
    64'h0100_0000_0000_0000,
    64'h8000_0000_0000_0000,
    64'h7FFF_FFFF_FFFF_FFFF,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h5555_5555_5555_5555,
    64'h0000_0200_0000_0000,
    64'h0000_0000_0000_0100,
    64'hFFFF_FF00_0000_0000,
    64'h0000_01FF_FFFF_FFFF,
    64'h0000_0101_0000_0000,
    64'h0000_0180_0000_0000,
    64'h00FF_FFFF_FFFF_FFFF
  };

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  logic [fsr_pkg::FSR_RAD_W-1:0]  radicand_i;
  logic                           done_o;
  logic [fsr_pkg::FSR_HALF_W-1:0] root_high_o;
  logic [fsr_pkg::FSR_HALF_W-1:0] root_low_o;

  logic [fsr_pkg::FSR_W-1:0] expected_roots[$];
  logic [fsr_pkg::FSR_W-1:0] oldest_root;
  int unsigned               mismatch_count = 0;

  fixed_point_sixteenth_root_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .radicand_i (radicand_i),
    .done_o     (done_o),
    .root_high_o(root_high_o),
    .root_low_o (root_low_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // multiplicative normalization: grow the product toward the radicand,
  // scaling the root by (1 + 2^-k) each time a candidate fits
  function automatic logic [fsr_pkg::FSR_W-1:0] sixteenth_root(
    input logic [fsr_pkg::FSR_RAD_W-1:0] radicand
  );
    logic [fsr_pkg::FSR_W-1:0] ceiling;
    logic [fsr_pkg::FSR_W-1:0] product;
    logic [fsr_pkg::FSR_W-1:0] trial;
    logic [fsr_pkg::FSR_W-1:0] root;
    ceiling = '0;
    ceiling[fsr_pkg::FSR_RAD_W+fsr_pkg::FSR_LIMIT_UP-1:fsr_pkg::FSR_LIMIT_UP] = radicand;
    product = fsr_pkg::FSR_F_ONE;
    root = fsr_pkg::FSR_R_ONE;
    for (int k = 0; k < fsr_pkg::FSR_ITERATIONS; k++) begin
      trial = product;
      // k = 0 shifts by nothing, so each step doubles
      for (int j = 0; j < fsr_pkg::FSR_ROOT_ORDER; j++) trial = trial + (trial >> k);
      if (trial <= ceiling) begin
        product = trial;
        root = root + (root >> k);
      end
    end
    return root;
  endfunction

  function automatic logic [fsr_pkg::FSR_RAD_W-1:0] random_radicand();
    logic [fsr_pkg::FSR_RAD_W-1:0] value;
    int unsigned                   pick;
    value = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    case (pick) inside
      4, 5: value = value & ((64'd1 << fsr_pkg::FSR_RAD_FRAC) - 64'd1);
      6: begin
        value = (64'd1 << fsr_pkg::FSR_RAD_FRAC) + 64'($urandom_range(0, 64)) - 64'd32;
      end
      7, 8: value = value >> $urandom_range(1, 63);
      9: begin
        if ($urandom_range(0, 1) == 0) value = 64'd1 << $urandom_range(0, 63);
        else value = ~(64'd1 << $urandom_range(0, 63));
      end
      default: ;
    endcase
    return value;
  endfunction

  // mostly short gaps, a few long enough to land anywhere in the busy window
  function automatic int unsigned random_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    if (roll < 95) return $urandom_range(5, 60);
    return $urandom_range(1800, 2600);
  endfunction

  // called at a rising edge; returns at the edge that takes the beat
  task automatic send_radicand(input logic [fsr_pkg::FSR_RAD_W-1:0] value);
    start <= 1'b1;
    radicand_i <= value;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_roots.push_back(sixteenth_root(value));
  endtask

  task automatic hold_off(input int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      radicand_i <= {$urandom, $urandom};
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_all_roots();
    start <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_corner_radicands();
    foreach (CORNER_RADICANDS[i]) begin
      send_radicand(CORNER_RADICANDS[i]);
      hold_off((i < 8) ? 0 : random_gap());
    end
  endtask

  task automatic test_pause_until_drained();
    for (int i = 0; i < 4; i++) begin
      send_radicand(random_radicand());
      if (i == 1) wait_for_all_roots();
    end
    wait_for_all_roots();
    hold_off($urandom_range(1, 5));
  endtask

  task automatic test_random_radicands();
    bit back_to_back;
    back_to_back = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % SEGMENT_ITEMS == 0) back_to_back = ($urandom_range(0, 3) == 0);
      send_radicand(random_radicand());
      hold_off(back_to_back ? 0 : random_gap());
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (expected_roots.size() == 0) begin
        $error("root beat with none expected: root_high_o=%h root_low_o=%h",
               root_high_o, root_low_o);
        mismatch_count++;
      end else begin
        oldest_root = expected_roots.pop_front();
        if (root_high_o !== oldest_root[fsr_pkg::FSR_W-1:fsr_pkg::FSR_HALF_W]) begin
          $error("root_high_o expected %h actual %h",
                 oldest_root[fsr_pkg::FSR_W-1:fsr_pkg::FSR_HALF_W], root_high_o);
          mismatch_count++;
        end
        if (root_low_o !== oldest_root[fsr_pkg::FSR_HALF_W-1:0]) begin
          $error("root_low_o expected %h actual %h",
                 oldest_root[fsr_pkg::FSR_HALF_W-1:0], root_low_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    radicand_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_radicands();
    test_pause_until_drained();
    test_random_radicands();

    wait_for_all_roots();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_roots.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
